### hdl/pts_pkg.sv
// Shared constants, codes and types for the priority task scheduler.
`default_nettype none
package pts_pkg;
	localparam int NUM_TASKS     = 16;
	localparam int NUM_RESOURCES = 8;
	localparam int PRIORITY_BITS = 4;

	localparam int SLOT_W = $clog2(NUM_TASKS);
	localparam int RES_IW = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;

	typedef logic [SLOT_W-1:0]        slot_t;
	typedef logic [PRIORITY_BITS-1:0] prio_t;
	typedef logic [RES_IW-1:0]        ridx_t;

	// request actions
	localparam logic [2:0] ACT_CREATE  = 3'd0;
	localparam logic [2:0] ACT_TICK    = 3'd1;
	localparam logic [2:0] ACT_SLEEP   = 3'd2;
	localparam logic [2:0] ACT_YIELD   = 3'd3;
	localparam logic [2:0] ACT_DESTROY = 3'd4;
	localparam logic [2:0] ACT_WAIT    = 3'd5;
	localparam logic [2:0] ACT_ACQUIRE = 3'd6;
	localparam logic [2:0] ACT_RELEASE = 3'd7;

	// slot states
	localparam logic [1:0] ST_READY    = 2'd0;
	localparam logic [1:0] ST_RUNNING  = 2'd1;
	localparam logic [1:0] ST_SLEEPING = 2'd2;
	localparam logic [1:0] ST_BLOCKED  = 2'd3;

	// result status
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_FULL    = 2'd1;
	localparam logic [1:0] STAT_NOCUR   = 2'd2;
	localparam logic [1:0] STAT_NOTHELD = 2'd3;

	// datapath commands
	localparam logic [3:0] CMD_NONE        = 4'd0;
	localparam logic [3:0] CMD_LOAD        = 4'd1;
	localparam logic [3:0] CMD_EVENT       = 4'd2;
	localparam logic [3:0] CMD_CREATE_STEP = 4'd3;
	localparam logic [3:0] CMD_TICK_STEP   = 4'd4;
	localparam logic [3:0] CMD_REL_STEP    = 4'd5;
	localparam logic [3:0] CMD_WAIT2       = 4'd6;
	localparam logic [3:0] CMD_DEMOTE      = 4'd7;
	localparam logic [3:0] CMD_PICK_STEP   = 4'd8;
	localparam logic [3:0] CMD_COMMIT      = 4'd9;
	localparam logic [3:0] CMD_OUT         = 4'd10;

	typedef struct packed {
		logic [2:0] act;
		logic       pres;
		logic       held;
		logic       last;
		logic       out_free;
	} sts_t;
endpackage
`default_nettype wire

### hdl/pts_dp.sv
// Scheduler datapath: task table, resource table, scan counter and result register.
`default_nettype none
module pts_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [3:0]        cmd,
	input  wire logic [2:0]        action,
	input  wire logic [3:0]        task_priority_in,
	input  wire logic [31:0]       sleep_ticks,
	input  wire logic [2:0]        resource_id,
	input  wire logic              out_stall,
	output pts_pkg::sts_t          sts,
	output logic                   out_valid,
	output logic [3:0]             running_slot,
	output logic                   running_valid,
	output logic [3:0]             created_slot,
	output logic [1:0]             status
);
	logic                  used_q [pts_pkg::NUM_TASKS];
	logic [1:0]            st_q   [pts_pkg::NUM_TASKS];
	pts_pkg::prio_t        prio_q [pts_pkg::NUM_TASKS];
	pts_pkg::prio_t        base_q [pts_pkg::NUM_TASKS];
	logic [63:0]           lr_q   [pts_pkg::NUM_TASKS];
	logic [63:0]           wake_q [pts_pkg::NUM_TASKS];
	pts_pkg::ridx_t        wres_q [pts_pkg::NUM_TASKS];
	logic                  held_q   [pts_pkg::NUM_RESOURCES];
	pts_pkg::slot_t        holder_q [pts_pkg::NUM_RESOURCES];

	logic [63:0]    tick_q;
	pts_pkg::slot_t cur_q, idx_q, best_q, hold_q, created_q;
	logic           pres_q, found_q, crfound_q, out_valid_q;
	logic [2:0]     act_q, res_q;
	pts_pkg::prio_t pin_q, pr_q, bprio_q;
	logic [31:0]    ticks_q;
	logic [63:0]    blr_q;
	logic [1:0]     stat_q;
	logic [3:0]     rslot_q, cslot_q;
	logic           rvalid_q;
	logic [1:0]     status_q;

	logic           res_ok, held_now, demote_ok, better, free_now;
	pts_pkg::ridx_t ridx;
	pts_pkg::slot_t hsel;

	assign res_ok    = int'(res_q) < pts_pkg::NUM_RESOURCES;
	assign ridx      = pts_pkg::ridx_t'(res_q);
	assign held_now  = res_ok && held_q[ridx];
	assign hsel      = holder_q[ridx];
	assign demote_ok = pres_q && used_q[cur_q] && (st_q[cur_q] == pts_pkg::ST_RUNNING);
	assign free_now  = !used_q[idx_q] && !crfound_q;
	assign better    = used_q[idx_q] && (st_q[idx_q] == pts_pkg::ST_READY) &&
		(!found_q || (prio_q[idx_q] > bprio_q) ||
		 ((prio_q[idx_q] == bprio_q) && (lr_q[idx_q] < blr_q)));

	assign sts.act      = act_q;
	assign sts.pres     = pres_q;
	assign sts.held     = held_now;
	assign sts.last     = idx_q == pts_pkg::slot_t'(pts_pkg::NUM_TASKS - 1);
	assign sts.out_free = !out_valid_q || !out_stall;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pts_pkg::NUM_TASKS; i++) begin
				used_q[i] <= 1'b0;
				st_q[i]   <= pts_pkg::ST_READY;
			end
			for (int r = 0; r < pts_pkg::NUM_RESOURCES; r++) held_q[r] <= 1'b0;
			tick_q      <= '0;
			cur_q       <= '0;
			pres_q      <= 1'b0;
			found_q     <= 1'b0;
			crfound_q   <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd == pts_pkg::CMD_OUT) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (cmd)
				pts_pkg::CMD_LOAD: begin
					idx_q     <= '0;
					crfound_q <= 1'b0;
				end
				pts_pkg::CMD_EVENT: begin
					idx_q <= '0;
					case (act_q)
						pts_pkg::ACT_TICK: tick_q <= tick_q + 64'd1;
						pts_pkg::ACT_SLEEP: if (pres_q) st_q[cur_q] <= pts_pkg::ST_SLEEPING;
						pts_pkg::ACT_DESTROY: if (pres_q) begin
							used_q[cur_q] <= 1'b0;
							st_q[cur_q]   <= pts_pkg::ST_READY;
							pres_q        <= 1'b0;
							cur_q         <= '0;
						end
						pts_pkg::ACT_WAIT: if (pres_q && held_now) st_q[cur_q] <= pts_pkg::ST_BLOCKED;
						pts_pkg::ACT_ACQUIRE: if (pres_q && res_ok) held_q[ridx] <= 1'b1;
						pts_pkg::ACT_RELEASE: if (held_now) held_q[ridx] <= 1'b0;
						default: ;
					endcase
				end
				pts_pkg::CMD_CREATE_STEP: begin
					idx_q <= idx_q + 1'b1;
					if (free_now) begin
						used_q[idx_q] <= 1'b1;
						st_q[idx_q]   <= pts_pkg::ST_READY;
						crfound_q     <= 1'b1;
					end
				end
				pts_pkg::CMD_TICK_STEP: begin
					idx_q <= idx_q + 1'b1;
					if (used_q[idx_q] && st_q[idx_q] == pts_pkg::ST_SLEEPING &&
					    tick_q >= wake_q[idx_q])
						st_q[idx_q] <= pts_pkg::ST_READY;
				end
				pts_pkg::CMD_REL_STEP: begin
					idx_q <= idx_q + 1'b1;
					if (used_q[idx_q] && st_q[idx_q] == pts_pkg::ST_BLOCKED &&
					    wres_q[idx_q] == ridx)
						st_q[idx_q] <= pts_pkg::ST_READY;
				end
				pts_pkg::CMD_DEMOTE: begin
					idx_q   <= '0;
					found_q <= 1'b0;
					if (demote_ok) st_q[cur_q] <= pts_pkg::ST_READY;
				end
				pts_pkg::CMD_PICK_STEP: begin
					idx_q <= idx_q + 1'b1;
					if (better) found_q <= 1'b1;
				end
				pts_pkg::CMD_COMMIT: begin
					if (found_q) begin
						st_q[best_q] <= pts_pkg::ST_RUNNING;
						cur_q        <= best_q;
						pres_q       <= 1'b1;
					end else begin
						cur_q  <= '0;
						pres_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload and table contents
	always_ff @(posedge clk) begin
		case (cmd)
			pts_pkg::CMD_LOAD: begin
				act_q     <= action;
				pin_q     <= pts_pkg::prio_t'(task_priority_in);
				ticks_q   <= sleep_ticks;
				res_q     <= resource_id;
				stat_q    <= (action == pts_pkg::ACT_CREATE) ? pts_pkg::STAT_FULL : pts_pkg::STAT_OK;
				created_q <= '0;
			end
			pts_pkg::CMD_EVENT: begin
				case (act_q)
					pts_pkg::ACT_SLEEP: begin
						if (pres_q) wake_q[cur_q] <= tick_q + {32'd0, ticks_q};
						else stat_q <= pts_pkg::STAT_NOCUR;
					end
					pts_pkg::ACT_DESTROY: if (!pres_q) stat_q <= pts_pkg::STAT_NOCUR;
					pts_pkg::ACT_WAIT: begin
						if (!pres_q) stat_q <= pts_pkg::STAT_NOCUR;
						else if (!held_now) stat_q <= pts_pkg::STAT_NOTHELD;
						else begin
							wres_q[cur_q] <= ridx;
							pr_q          <= prio_q[cur_q];
							hold_q        <= hsel;
						end
					end
					pts_pkg::ACT_ACQUIRE: begin
						if (!pres_q) stat_q <= pts_pkg::STAT_NOCUR;
						else if (res_ok) holder_q[ridx] <= cur_q;
					end
					pts_pkg::ACT_RELEASE: begin
						if (!held_now) stat_q <= pts_pkg::STAT_NOTHELD;
						else prio_q[hsel] <= base_q[hsel];
					end
					default: ;
				endcase
			end
			pts_pkg::CMD_CREATE_STEP: if (free_now) begin
				prio_q[idx_q] <= pin_q;
				base_q[idx_q] <= pin_q;
				lr_q[idx_q]   <= '0;
				created_q     <= idx_q;
				stat_q        <= pts_pkg::STAT_OK;
			end
			// one-level inheritance: raise the holder to the waiter's priority
			pts_pkg::CMD_WAIT2: if (prio_q[hold_q] < pr_q) prio_q[hold_q] <= pr_q;
			pts_pkg::CMD_DEMOTE: if (demote_ok) lr_q[cur_q] <= tick_q;
			pts_pkg::CMD_PICK_STEP: if (better) begin
				best_q  <= idx_q;
				bprio_q <= prio_q[idx_q];
				blr_q   <= lr_q[idx_q];
			end
			pts_pkg::CMD_OUT: begin
				rslot_q  <= pres_q ? 4'(cur_q) : 4'd0;
				rvalid_q <= pres_q;
				cslot_q  <= 4'(created_q);
				status_q <= stat_q;
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign running_slot  = rslot_q;
	assign running_valid = rvalid_q;
	assign created_slot  = cslot_q;
	assign status        = status_q;
endmodule
`default_nettype wire

### hdl/pts_ctrl.sv
// Scheduler controller: sequences event, slot scans, selection and result load.
`default_nettype none
module pts_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire pts_pkg::sts_t sts,
	output logic               in_stall,
	output logic [3:0]         cmd
);
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_EVT    = 4'd1;
	localparam logic [3:0] S_CRSCAN = 4'd2;
	localparam logic [3:0] S_TKSCAN = 4'd3;
	localparam logic [3:0] S_RLSCAN = 4'd4;
	localparam logic [3:0] S_WAIT2  = 4'd5;
	localparam logic [3:0] S_SCHED  = 4'd6;
	localparam logic [3:0] S_PICK   = 4'd7;
	localparam logic [3:0] S_COMMIT = 4'd8;
	localparam logic [3:0] S_OUT    = 4'd9;

	logic [3:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = pts_pkg::CMD_NONE;
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				cmd     = pts_pkg::CMD_LOAD;
				state_d = S_EVT;
			end
			S_EVT: begin
				cmd = pts_pkg::CMD_EVENT;
				case (sts.act)
					pts_pkg::ACT_CREATE:  state_d = S_CRSCAN;
					pts_pkg::ACT_TICK:    state_d = S_TKSCAN;
					pts_pkg::ACT_ACQUIRE: state_d = S_OUT;
					pts_pkg::ACT_WAIT:    state_d = (sts.pres && sts.held) ? S_WAIT2 : S_SCHED;
					pts_pkg::ACT_RELEASE: state_d = sts.held ? S_RLSCAN : S_SCHED;
					default:              state_d = S_SCHED;
				endcase
			end
			S_CRSCAN: begin
				cmd = pts_pkg::CMD_CREATE_STEP;
				if (sts.last) state_d = S_OUT;
			end
			S_TKSCAN: begin
				cmd = pts_pkg::CMD_TICK_STEP;
				if (sts.last) state_d = S_SCHED;
			end
			S_RLSCAN: begin
				cmd = pts_pkg::CMD_REL_STEP;
				if (sts.last) state_d = S_SCHED;
			end
			S_WAIT2: begin
				cmd     = pts_pkg::CMD_WAIT2;
				state_d = S_SCHED;
			end
			S_SCHED: begin
				cmd     = pts_pkg::CMD_DEMOTE;
				state_d = S_PICK;
			end
			S_PICK: begin
				cmd = pts_pkg::CMD_PICK_STEP;
				if (sts.last) state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd     = pts_pkg::CMD_COMMIT;
				state_d = S_OUT;
			end
			S_OUT: if (sts.out_free) begin
				cmd     = pts_pkg::CMD_OUT;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign in_stall = state_q != S_IDLE;
endmodule
`default_nettype wire

### hdl/priority_task_scheduler.sv
// Each slot pass steps through the task slots one at a time via the scan counter of the datapath;
// tick and release of a held resource do a wake pass then a selection pass, create does a
// free-slot pass only, acquire no pass, others one selection pass (plus output wait).
// One request at a time: in_stall is high from request load until the result is loaded.
// Reset (arst_n low, asynchronous): all slots free, no resources held, tick count zero,
// no running task, no result pending.
`default_nettype none
module priority_task_scheduler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  action,
	input  wire logic [3:0]  task_priority_in,
	input  wire logic [31:0] sleep_ticks,
	input  wire logic [2:0]  resource_id,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       running_slot,
	output logic             running_valid,
	output logic [3:0]       created_slot,
	output logic [1:0]       status
);
	pts_pkg::sts_t sts;
	logic [3:0]    cmd;

	pts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	pts_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.action           (action),
		.task_priority_in (task_priority_in),
		.sleep_ticks      (sleep_ticks),
		.resource_id      (resource_id),
		.out_stall        (out_stall),
		.sts              (sts),
		.out_valid        (out_valid),
		.running_slot     (running_slot),
		.running_valid    (running_valid),
		.created_slot     (created_slot),
		.status           (status)
	);
endmodule
`default_nettype wire
